// File: design/mct_pkg.sv
package mct_pkg;

  // Field widths of the request and result words.
  localparam int ID_W     = 16;
  localparam int IDX_IN_W = 8;
  localparam int VAL_IN_W = 64;
  localparam int CIU_W    = 9;
  localparam int STATUS_W = 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default sizing of the counter store.
  localparam int MAX_COUNTERS_DFLT = 256;
  localparam int VALUE_BITS_DFLT   = 64;

  // Register reset values.
  localparam logic [ID_W-1:0]  OWN_ID_RST = '0;
  localparam logic [CIU_W-1:0] CIU_RST    = 9'd256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTERS_IN_USE = 2'd1;

  // Update kinds.
  localparam logic KIND_INDEPENDENT = 1'b0;
  localparam logic KIND_CONTINUING  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ADVANCING = 2'd3;

  // Decision on one request, from the check unit to the sequencer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                commit;
    logic                ret_prev;
  } mct_verdict_t;

endpackage

// File: design/mct_check.sv
module mct_check #(
  parameter int MAX_COUNTERS = mct_pkg::MAX_COUNTERS_DFLT,
  parameter int VALUE_BITS   = mct_pkg::VALUE_BITS_DFLT
) (
  input  logic                          kind,
  input  logic [mct_pkg::ID_W-1:0]      subsystem_id,
  input  logic [mct_pkg::IDX_IN_W-1:0]  counter_index,
  input  logic [VALUE_BITS-1:0]         new_value,
  input  logic [VALUE_BITS-1:0]         old_value,
  input  logic [mct_pkg::ID_W-1:0]      own_subsystem_id,
  input  logic [mct_pkg::CIU_W-1:0]     counters_in_use,
  output mct_pkg::mct_verdict_t         verdict
);
  import mct_pkg::*;

  logic id_ok;
  logic idx_ok;
  logic val_ok;

  // Index must lie below both the configured count and the store depth.
  assign id_ok  = (subsystem_id == own_subsystem_id);
  assign idx_ok = (32'(counter_index) < 32'(counters_in_use)) &&
                  (32'(counter_index) < MAX_COUNTERS);
  assign val_ok = (kind == KIND_CONTINUING) ? (new_value >= old_value)
                                            : (new_value > old_value);

  // Checks are taken in order: id, then index, then value.
  always_comb begin
    verdict.status   = ST_OK;
    verdict.commit   = 1'b0;
    verdict.ret_prev = 1'b0;
    if (!id_ok) begin
      verdict.status = ST_BAD_ID;
    end else if (!idx_ok) begin
      verdict.status = ST_BAD_INDEX;
    end else if (!val_ok) begin
      verdict.status = ST_NOT_ADVANCING;
    end else begin
      verdict.commit   = 1'b1;
      verdict.ret_prev = (kind == KIND_CONTINUING);
    end
  end

endmodule

// File: design/monotonic_counter_table.sv
// Table of monotonic counters held in one synchronous memory.
// Request channel (in_*): kind, subsystem_id, counter_index, new_value. Each
// accepted word yields exactly one result word on the out_* channel: status
// and previous_value (old value on a successful continuing update, else 0).
// Configuration channel (cfg_*): index 0 writes own_subsystem_id, index 1
// writes counters_in_use; other indexes are ignored. cfg_ready is always high.
// The result word is registered: the request and the entry read from the
// store are captured as the request is accepted, checked in S_CHECK, and
// the verdict loads the output register. The block finishes one request,
// memory read, then check and write-back of the entry, before the next.
// Reset: after rst_n is released the store is cleared by a sweep that writes
// one entry a cycle, MAX_COUNTERS cycles in all, while in_ready stays low.
// Registers return to own_subsystem_id = 0 and counters_in_use = 256.
// Stall: the result sits in an output register until out_ready. A new
// request is taken while a result waits only in the cycle that it leaves, so
// a stalled receiver holds off the request side.
module monotonic_counter_table #(
  parameter int MAX_COUNTERS = mct_pkg::MAX_COUNTERS_DFLT,
  parameter int VALUE_BITS   = mct_pkg::VALUE_BITS_DFLT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [mct_pkg::ID_W-1:0]        in_subsystem_id,
  input  logic [mct_pkg::IDX_IN_W-1:0]    in_counter_index,
  input  logic [mct_pkg::VAL_IN_W-1:0]    in_new_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mct_pkg::STATUS_W-1:0]    out_status,
  output logic [mct_pkg::VAL_IN_W-1:0]    out_previous_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mct_pkg::*;

  localparam int IDX_W = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [ID_W-1:0]       own_id_r;
  logic [CIU_W-1:0]      ciu_r;

  logic                  req_kind_r;
  logic [ID_W-1:0]       req_id_r;
  logic [IDX_IN_W-1:0]   req_idx_r;
  logic [VALUE_BITS-1:0] req_val_r;

  logic [VALUE_BITS-1:0] mem [MAX_COUNTERS];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VAL_IN_W-1:0]   out_prev_r;

  logic                  in_fire;
  logic                  cfg_fire;
  mct_verdict_t          verdict;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= OWN_ID_RST;
      ciu_r    <= CIU_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_OWN_ID:          own_id_r <= cfg_data;
        REG_COUNTERS_IN_USE: ciu_r    <= cfg_data[CIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clearing sweep, then read / check-and-write per request.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(MAX_COUNTERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Request capture; the value is cut to the stored width.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind_r <= in_kind;
      req_id_r   <= in_subsystem_id;
      req_idx_r  <= in_counter_index;
      req_val_r  <= in_new_value[VALUE_BITS-1:0];
    end
  end

  // Decision on the captured request against the entry just read.
  mct_check #(
    .MAX_COUNTERS (MAX_COUNTERS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_check (
    .kind             (req_kind_r),
    .subsystem_id     (req_id_r),
    .counter_index    (req_idx_r),
    .new_value        (req_val_r),
    .old_value        (rd_data_r),
    .own_subsystem_id (own_id_r),
    .counters_in_use  (ciu_r),
    .verdict          (verdict)
  );

  // Write port is shared by the clearing sweep and the write-back.
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == S_CHECK) && verdict.commit;
      mem_waddr = IDX_W'(req_idx_r);
      mem_wdata = req_val_r;
    end
  end

  // Counter store. The next read is issued only after the write-back edge,
  // so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_r <= mem[IDX_W'(in_counter_index)];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_CHECK) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      out_status_r <= verdict.status;
      out_prev_r   <= verdict.ret_prev ? VAL_IN_W'(rd_data_r) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_previous_value = out_prev_r;

endmodule

// File: design/mct_checker.sv
module mct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mct_pkg::STATUS_W-1:0]    out_status,
  input logic [mct_pkg::VAL_IN_W-1:0]    out_previous_value
);
  import mct_pkg::*;

  // A stalled result word holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_previous_value))
    else $error("result word changed while stalled");

  // Every accepted request shows its result once it has passed the check state and the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // The block works on one request at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in the check stage");

  // A failed request never returns a stored value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_previous_value == '0))
    else $error("nonzero previous value on an error result");

endmodule

bind monotonic_counter_table mct_checker u_mct_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_previous_value (out_previous_value)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import mct_pkg::*;

  localparam int NUM_COUNTERS = MAX_COUNTERS_DFLT;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 150;

  // Register indexes outside the map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic                kind;
    logic [ID_W-1:0]     sub_id;
    logic [IDX_IN_W-1:0] idx;
    logic [VAL_IN_W-1:0] value;
    bit                  hold;
  } update_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VAL_IN_W-1:0] prev;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_kind = 1'b0;
  logic [ID_W-1:0]        in_subsystem_id = '0;
  logic [IDX_IN_W-1:0]    in_counter_index = '0;
  logic [VAL_IN_W-1:0]    in_new_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [VAL_IN_W-1:0]    out_previous_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Requests waiting to be sent and outcomes waiting to be seen.
  update_t  update_q[$];
  outcome_t outcome_q[$];

  // Mirror of the counter table and its registers.
  logic [VAL_IN_W-1:0] counter_model [NUM_COUNTERS];
  logic [ID_W-1:0]     own_id_m;
  logic [CIU_W-1:0]    in_use_m;

  // Rough idea of each counter's value, used only to aim new values.
  logic [VAL_IN_W-1:0] value_hint [NUM_COUNTERS] = '{default: '0};

  bit in_taken;
  bit steady;
  int results_seen;
  int error_count;
  int cycle_count;

  monotonic_counter_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_subsystem_id   (in_subsystem_id),
    .in_counter_index  (in_counter_index),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_previous_value(out_previous_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one update to the mirror table and return the outcome it gives.
  function automatic outcome_t apply_update(logic kind, logic [ID_W-1:0] sub_id,
                                            logic [IDX_IN_W-1:0] idx,
                                            logic [VAL_IN_W-1:0] value);
    outcome_t res;
    logic [VAL_IN_W-1:0] old;
    bit advancing;
    res.status = ST_OK;
    res.prev   = '0;
    if (sub_id != own_id_m) begin
      res.status = ST_BAD_ID;
    end else if ({1'b0, idx} >= in_use_m || int'(idx) >= NUM_COUNTERS) begin
      res.status = ST_BAD_INDEX;
    end else begin
      old = counter_model[idx];
      advancing = (kind == KIND_INDEPENDENT) ? (value > old) : (value >= old);
      if (!advancing) begin
        res.status = ST_NOT_ADVANCING;
      end else begin
        if (kind == KIND_CONTINUING) begin
          res.prev = old;
        end
        counter_model[idx] = value;
      end
    end
    return res;
  endfunction

  // Watch all three channels at the rising edge and check every result word.
  always @(posedge clk) begin : watch_ports
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counter_model[i] = '0;
      end
      own_id_m = OWN_ID_RST;
      in_use_m = CIU_RST;
      in_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OWN_ID:          own_id_m = cfg_data;
          REG_COUNTERS_IN_USE: in_use_m = cfg_data[CIU_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with none expected, status %0d prev %0h",
                   $time, out_status, out_previous_value);
          error_count++;
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
            error_count++;
          end
          if (out_previous_value !== want.prev) begin
            $display("%0t: previous_value mismatch, expected %0h, got %0h",
                     $time, want.prev, out_previous_value);
            error_count++;
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        outcome_q.push_back(apply_update(in_kind, in_subsystem_id,
                                         in_counter_index, in_new_value));
      end
    end
  end

  // Request driver: keeps a word steady until taken, idles at random.
  always @(negedge clk) begin : drive_requests
    update_t nxt;
    bit blocked;
    if (rst_n && (!in_valid || in_taken)) begin
      blocked = update_q.size() == 0 ||
                (update_q[0].hold && outcome_q.size() != 0) ||
                (!steady && $urandom_range(99) < 20);
      if (!blocked) begin
        nxt = update_q.pop_front();
        in_valid         <= 1'b1;
        in_kind          <= nxt.kind;
        in_subsystem_id  <= nxt.sub_id;
        in_counter_index <= nxt.idx;
        in_new_value     <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus a long hold-off now and then.
  always @(negedge clk) begin : drive_result_ready
    int hold_left;
    int next_hold_at;
    if (!rst_n) begin
      hold_left    = 0;
      next_hold_at = 100;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left    = LONG_HOLD;
      next_hold_at = next_hold_at + 400;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // Run time limit.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_update(logic kind, logic [ID_W-1:0] sub_id,
                             logic [IDX_IN_W-1:0] idx, logic [VAL_IN_W-1:0] value);
    update_t u;
    u.kind   = kind;
    u.sub_id = sub_id;
    u.idx    = idx;
    u.value  = value;
    u.hold   = 1'b0;
    update_q.push_back(u);
  endtask

  // Random updates for one setting: mostly valid ids and in-range indexes,
  // with values aimed just above, at or below the counter's likely value.
  task automatic queue_random_updates(int count, logic [ID_W-1:0] own, int in_use);
    update_t u;
    int eff;
    int pick;
    logic [VAL_IN_W-1:0] base;
    eff = (in_use > NUM_COUNTERS) ? NUM_COUNTERS : in_use;
    for (int n = 0; n < count; n++) begin
      u.kind   = 1'($urandom_range(1));
      u.sub_id = ($urandom_range(99) < 88) ? own : ID_W'($urandom_range(65535));
      pick = $urandom_range(99);
      if (eff > 0 && pick < 45) begin
        u.idx = IDX_IN_W'($urandom_range((eff < 4) ? eff - 1 : 3));
      end else if (eff > 0 && pick < 88) begin
        u.idx = IDX_IN_W'($urandom_range(eff - 1));
      end else begin
        u.idx = IDX_IN_W'($urandom_range(255));
      end
      base = value_hint[u.idx];
      pick = $urandom_range(99);
      if (pick < 36) begin
        u.value = base + $urandom_range(3, 1);
      end else if (pick < 52) begin
        u.value = base;
      end else if (pick < 64) begin
        u.value = base - $urandom_range(2, 1);
      end else if (pick < 72) begin
        u.value = '0;
      end else if (pick < 74) begin
        u.value = '1;
      end else if (pick < 86) begin
        u.value = {$urandom, $urandom};
      end else begin
        u.value = base + ({$urandom, $urandom} >> $urandom_range(63, 1));
      end
      if (u.value > value_hint[u.idx]) begin
        value_hint[u.idx] = u.value;
      end
      u.hold = ($urandom_range(59) == 0);
      update_q.push_back(u);
    end
  endtask

  // Wait until every word is sent and answered, then let the pipeline settle.
  task automatic wait_for_idle();
    do begin
      @(posedge clk);
      #1;
    end while (update_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Test sequence: directed checks per setting, then random phases.
  initial begin : run_test
    logic [ID_W-1:0] own;
    int in_use;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: id 0, all counters in use.
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd0, 64'd0);
    push_update(KIND_CONTINUING,  16'h0000, 8'd0, 64'd0);
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd0, 64'd5);
    push_update(KIND_CONTINUING,  16'h0000, 8'd0, 64'd5);
    push_update(KIND_CONTINUING,  16'h0000, 8'd0, 64'd4);
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd0, 64'd5);
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd255, '1);
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd255, '1);
    push_update(KIND_CONTINUING,  16'h0000, 8'd255, '1);
    push_update(KIND_CONTINUING,  16'hFFFF, 8'd0, 64'd9);
    push_update(KIND_INDEPENDENT, 16'h8000, 8'd128, 64'd1);
    wait_for_idle();

    // No counters in use: the upper data bits must not leak into the count.
    write_reg(REG_OWN_ID, 16'hFFFF);
    write_reg(REG_COUNTERS_IN_USE, 16'hFE00);
    write_reg(REG_SPARE_2, 16'h0001);
    write_reg(REG_SPARE_3, 16'h5555);
    push_update(KIND_INDEPENDENT, 16'hFFFF, 8'd0, 64'd100);
    push_update(KIND_CONTINUING,  16'hFFFF, 8'd255, 64'd0);
    push_update(KIND_INDEPENDENT, 16'h0000, 8'd0, 64'd100);
    wait_for_idle();

    // Count above the table size acts as the full table.
    write_reg(REG_OWN_ID, 16'h5AC3);
    write_reg(REG_COUNTERS_IN_USE, 16'h01FF);
    push_update(KIND_CONTINUING,  16'h5AC3, 8'd255, '1);
    push_update(KIND_INDEPENDENT, 16'h5AC3, 8'd200, 64'd1);
    wait_for_idle();

    // A single counter in use.
    write_reg(REG_COUNTERS_IN_USE, 16'd1);
    push_update(KIND_INDEPENDENT, 16'h5AC3, 8'd1, 64'd7);
    push_update(KIND_INDEPENDENT, 16'h5AC3, 8'd0, 64'd6);
    push_update(KIND_CONTINUING,  16'h5AC3, 8'd128, 64'd0);
    push_update(KIND_CONTINUING,  16'h5AC3, 8'd0, 64'd6);
    wait_for_idle();

    // Random phases over a spread of settings.
    for (int phase = 0; phase < 6; phase++) begin
      own = ID_W'($urandom_range(65535));
      case (phase)
        0: in_use = NUM_COUNTERS;
        1: in_use = $urandom_range(511, 257);
        2: in_use = $urandom_range(8, 1);
        3: begin
          own    = '0;
          in_use = $urandom_range(255, 9);
        end
        4: begin
          own    = '1;
          in_use = 0;
        end
        default: in_use = 255;
      endcase
      write_reg(REG_OWN_ID, own);
      write_reg(REG_COUNTERS_IN_USE, CFG_DATA_W'(in_use));
      steady = (phase == 3);
      queue_random_updates((phase == 4) ? 40 : 160, own, in_use);
      wait_for_idle();
      steady = 1'b0;
    end

    repeat (6) @(posedge clk);
    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
